// File: rtl/core/sht_pkg.sv
// Shared types and constants for the SHT1x two-wire measurement master.
// Used by sht_seq and sht11_measurement_master_top; depends on nothing.
package sht_pkg;

  localparam int unsigned PHASE_TICKS_W   = 16;
  localparam int unsigned READY_TIMEOUT_W = 20;
  localparam int unsigned CFG_DATA_W      = 20;
  localparam int unsigned READING_W       = 16;
  localparam int unsigned IN_TDATA_W      = 16;
  localparam int unsigned OUT_TDATA_W     = 24;

  localparam logic [PHASE_TICKS_W-1:0]   PHASE_TICKS_RESET   = 16'd1;
  localparam logic [READY_TIMEOUT_W-1:0] READY_TIMEOUT_RESET = 20'd250000;
  localparam logic [READING_W-1:0]       TIMEOUT_READING     = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ACK   = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef enum logic {
    CFG_PHASE_TICKS   = 1'b0,
    CFG_READY_TIMEOUT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

  typedef struct packed {
    logic [PHASE_TICKS_W-1:0]   phase_ticks;
    logic [READY_TIMEOUT_W-1:0] ready_timeout;
  } cfg_t;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    status_t              status;
    logic                 done_res;
    logic                 busy_res;
    logic                 data_pull_low;
    logic                 clock_line;
  } result_t;

endpackage

// File: rtl/core/sht_seq.sv
// Bus sequencer of the SHT1x measurement master: holds the phase state and
// computes one result per accepted beat. Depends on sht_pkg.
module sht_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              kind,
  input  logic [7:0]        cmd_byte,
  input  logic              data_line,
  input  sht_pkg::cfg_t     cfg,
  output sht_pkg::result_t  res
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S0       = 5'd1,
    PH_S1       = 5'd2,
    PH_S2       = 5'd3,
    PH_S3       = 5'd4,
    PH_S4       = 5'd5,
    PH_S5       = 5'd6,
    PH_S6       = 5'd7,
    PH_CMD_SET  = 5'd8,
    PH_CMD_HIGH = 5'd9,
    PH_CMD_LOW  = 5'd10,
    PH_ACK_REL  = 5'd11,
    PH_ACK_HIGH = 5'd12,
    PH_ACK_LOW  = 5'd13,
    PH_WAIT     = 5'd14,
    PH_RD_HIGH  = 5'd15,
    PH_RD_LOW   = 5'd16,
    PH_MA_SET   = 5'd17,
    PH_MA_HIGH  = 5'd18,
    PH_MA_LOW   = 5'd19
  } phase_t;

  phase_t                                   phase_r, phase_nxt;
  logic [3:0]                               bit_cnt_r, bit_cnt_nxt;
  logic [sht_pkg::PHASE_TICKS_W-1:0]        hold_cnt_r, hold_cnt_nxt, hold_inc, hold_lim;
  logic [sht_pkg::READY_TIMEOUT_W-1:0]      wait_cnt_r, wait_cnt_nxt, wait_inc, wait_lim;
  logic [7:0]                               cmd_sh_r, cmd_sh_nxt;
  logic [sht_pkg::READING_W-1:0]            rd_sh_r, rd_sh_nxt;
  logic                                     ack_miss_r, ack_miss_nxt;
  logic                                     done;
  sht_pkg::status_t                         st;
  logic [sht_pkg::READING_W-1:0]            rd;
  logic                                     clk_ln, pull_ln, cmd_pull, ma_pull;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    hold_cnt_nxt = hold_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    cmd_sh_nxt   = cmd_sh_r;
    rd_sh_nxt    = rd_sh_r;
    ack_miss_nxt = ack_miss_r;
    done         = 1'b0;
    st           = sht_pkg::ST_OK;
    rd           = '0;
    hold_lim     = (cfg.phase_ticks == '0) ? sht_pkg::PHASE_TICKS_W'(1) : cfg.phase_ticks;
    wait_lim     = (cfg.ready_timeout == '0) ?
                   sht_pkg::READY_TIMEOUT_W'(1) : cfg.ready_timeout;
    hold_inc     = hold_cnt_r + 1'b1;
    wait_inc     = wait_cnt_r + 1'b1;
    if (kind == sht_pkg::KIND_START) begin
      if (phase_r == PH_IDLE) begin
        cmd_sh_nxt   = cmd_byte;
        bit_cnt_nxt  = '0;
        hold_cnt_nxt = '0;
        wait_cnt_nxt = '0;
        rd_sh_nxt    = '0;
        ack_miss_nxt = 1'b0;
        phase_nxt    = PH_S0;
      end
    end else if (phase_r != PH_IDLE) begin
      hold_cnt_nxt = hold_inc;
      if (hold_inc >= hold_lim) begin
        hold_cnt_nxt = '0;
        case (phase_r)
          PH_S0:       phase_nxt = PH_S1;
          PH_S1:       phase_nxt = PH_S2;
          PH_S2:       phase_nxt = PH_S3;
          PH_S3:       phase_nxt = PH_S4;
          PH_S4:       phase_nxt = PH_S5;
          PH_S5:       phase_nxt = PH_S6;
          PH_S6: begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_CMD_SET;
          end
          PH_CMD_SET:  phase_nxt = PH_CMD_HIGH;
          PH_CMD_HIGH: phase_nxt = PH_CMD_LOW;
          PH_CMD_LOW: begin
            if (bit_cnt_r >= 4'd7) begin
              phase_nxt = PH_ACK_REL;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              cmd_sh_nxt  = {cmd_sh_r[6:0], 1'b0};
              phase_nxt   = PH_CMD_SET;
            end
          end
          PH_ACK_REL:  phase_nxt = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (data_line) begin
              ack_miss_nxt = 1'b1;
            end
            phase_nxt = PH_ACK_LOW;
          end
          PH_ACK_LOW: begin
            wait_cnt_nxt = '0;
            phase_nxt    = PH_WAIT;
          end
          PH_WAIT: begin
            if (!data_line) begin
              bit_cnt_nxt = '0;
              rd_sh_nxt   = '0;
              phase_nxt   = PH_RD_HIGH;
            end else begin
              wait_cnt_nxt = wait_inc;
              if (wait_inc >= wait_lim) begin
                done      = 1'b1;
                st        = sht_pkg::ST_TIMEOUT;
                rd        = sht_pkg::TIMEOUT_READING;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_RD_HIGH: begin
            rd_sh_nxt = {rd_sh_r[sht_pkg::READING_W-2:0], data_line};
            phase_nxt = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            if (bit_cnt_r[2:0] == 3'd7) begin
              phase_nxt = PH_MA_SET;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              phase_nxt   = PH_RD_HIGH;
            end
          end
          PH_MA_SET:   phase_nxt = PH_MA_HIGH;
          PH_MA_HIGH:  phase_nxt = PH_MA_LOW;
          PH_MA_LOW: begin
            if (bit_cnt_r == 4'd15) begin
              done      = 1'b1;
              st        = ack_miss_r ? sht_pkg::ST_NO_ACK : sht_pkg::ST_OK;
              rd        = rd_sh_r;
              phase_nxt = PH_IDLE;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              phase_nxt   = PH_RD_HIGH;
            end
          end
          default:     phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Line levels follow the phase that holds after this beat.
  always_comb begin
    cmd_pull = ~cmd_sh_nxt[7];
    ma_pull  = (bit_cnt_nxt == 4'd7);
    clk_ln   = 1'b0;
    pull_ln  = 1'b0;
    case (phase_nxt)
      PH_S1, PH_S2, PH_S4, PH_S5: clk_ln = 1'b1;
      default:                    clk_ln = 1'b0;
    endcase
    case (phase_nxt)
      PH_S2, PH_S3, PH_S4:        pull_ln = 1'b1;
      PH_CMD_SET, PH_CMD_LOW:     pull_ln = cmd_pull;
      PH_CMD_HIGH: begin
        clk_ln  = 1'b1;
        pull_ln = cmd_pull;
      end
      PH_ACK_HIGH, PH_RD_HIGH:    clk_ln = 1'b1;
      PH_MA_SET, PH_MA_LOW:       pull_ln = ma_pull;
      PH_MA_HIGH: begin
        clk_ln  = 1'b1;
        pull_ln = ma_pull;
      end
      default:                    pull_ln = 1'b0;
    endcase
  end

  always_comb begin
    res.clock_line    = clk_ln;
    res.data_pull_low = pull_ln;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.status        = st;
    res.reading       = rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      hold_cnt_r <= '0;
      wait_cnt_r <= '0;
      cmd_sh_r   <= '0;
      rd_sh_r    <= '0;
      ack_miss_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      cmd_sh_r   <= cmd_sh_nxt;
      rd_sh_r    <= rd_sh_nxt;
      ack_miss_r <= ack_miss_nxt;
    end
  end

endmodule

// File: rtl/core/sht11_measurement_master_top.sv
// Top level of the SHT1x two-wire measurement master: stream ports, the
// configuration registers and the result register. Depends on sht_pkg, sht_seq.
//
// Every input beat yields exactly one result beat, and the block takes one beat
// per clock: the sequencer state and the result register are updated in the
// cycle a beat is accepted, and a new beat is taken whenever the result register
// is empty or its beat is being taken in the same cycle. An idle start beat loads the
// command byte; tick beats then step the bus phases, each held for phase_ticks
// ticks, and the beat that finishes a transfer carries done, status and reading.
module sht11_measurement_master_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sht_pkg::IN_TDATA_W-1:0]      in_tdata,  // cmd_byte, data_line, zero pad
  input  logic                                in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // clock_line, data_pull_low, busy_res, done_res, status, reading, zero pad
  output logic [sht_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sht_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sht_pkg::cfg_t    cfg_r;
  sht_pkg::result_t res;
  logic             out_valid_r;
  sht_pkg::result_t out_res_r;
  logic             step;

  assign in_tready = ~out_valid_r | out_tready;
  assign step      = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks   <= sht_pkg::PHASE_TICKS_RESET;
      cfg_r.ready_timeout <= sht_pkg::READY_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sht_pkg::CFG_PHASE_TICKS:
          cfg_r.phase_ticks <= cfg_wdata[sht_pkg::PHASE_TICKS_W-1:0];
        sht_pkg::CFG_READY_TIMEOUT:
          cfg_r.ready_timeout <= cfg_wdata[sht_pkg::READY_TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  sht_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .kind      (in_tuser),
    .cmd_byte  (in_tdata[7:0]),
    .data_line (in_tdata[8]),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.reading,
                       out_res_r.status,
                       out_res_r.done_res,
                       out_res_r.busy_res,
                       out_res_r.data_pull_low,
                       out_res_r.clock_line};

endmodule
